/* design/bta_pkg.sv */
// Shared types and constants for the buddy tree allocator.
// No dependencies; imported by every module of the block.
package bta_pkg;

    localparam int REQ_W    = 25;
    localparam int ADDR_W   = 32;
    localparam int RB_W     = 25;
    localparam int MINB_W   = 17;
    localparam int CFGL_W   = 4;
    localparam int NODE_O_W = 10;
    localparam int LVL_O_W  = 4;
    localparam int STAT_W   = 2;
    localparam int CIDX_W   = 2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_BLOCK  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CIDX_W-1:0] CFG_LEVELS = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_REGION = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MINB   = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_BASE   = 2'd3;

    localparam logic [CFGL_W-1:0] LEVELS_RST = 4'd10;
    localparam logic [RB_W-1:0]   REGION_RST = 25'd1048576;
    localparam logic [MINB_W-1:0] MINB_RST   = 17'd1024;
    localparam logic [ADDR_W-1:0] BASE_RST   = 32'd0;

    typedef struct packed {
        logic alloc;
        logic blocked;
    } node_bits_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_A_LEVEL,
        ST_A_SCAN_RD,
        ST_A_SCAN_CHK,
        ST_A_MARK,
        ST_A_ANC_RD,
        ST_A_ANC_CHK,
        ST_A_MUL,
        ST_A_ADDR,
        ST_F_CHECK,
        ST_F_WAIT,
        ST_F_DESC_RD,
        ST_F_DESC_CHK,
        ST_F_CLEAR,
        ST_F_BUD_RD,
        ST_F_BUD_CHK,
        ST_F_PAR_RD,
        ST_F_PAR_WR,
        ST_SUB_INIT,
        ST_SUB_RD,
        ST_SUB_WR,
        ST_DONE
    } state_t;

endpackage

/* design/bta_divider.sv */
// Restoring divider, one quotient bit per cycle, for the free alignment search.
// Depends on bta_pkg for operand widths.
module bta_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [bta_pkg::ADDR_W-1:0] dividend,
    input  logic [bta_pkg::RB_W-1:0]   divisor,
    output logic                       done,
    output logic [bta_pkg::ADDR_W-1:0] quotient,
    output logic [bta_pkg::RB_W-1:0]   remainder
);
    import bta_pkg::*;

    localparam int CNT_W = $clog2(ADDR_W + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ADDR_W-1:0] quo_reg, quo_next;
    logic [RB_W-1:0]   rem_reg, rem_next;
    logic [RB_W-1:0]   div_reg, div_next;
    logic [RB_W:0]     trial;

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, quo_reg[ADDR_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = RB_W'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[ADDR_W-2:0], 1'b1};
            end else begin
                rem_next = trial[RB_W-1:0];
                quo_next = {quo_reg[ADDR_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ADDR_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* design/bta_node_store.sv */
// Node state memory: allocated and blocked bit per tree node, one port.
// Sweeps every entry to zero after reset. Depends on bta_pkg.
module bta_node_store #(
    parameter int NW = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rd_en,
    input  logic                wr_en,
    input  logic [NW-1:0]       addr,
    input  bta_pkg::node_bits_t wdata,
    output bta_pkg::node_bits_t rdata,
    output logic                clr_busy
);
    import bta_pkg::*;

    node_bits_t        mem [2**NW];
    node_bits_t        rdata_reg;
    logic [NW:0]       clr_cnt_reg, clr_cnt_next;

    assign clr_busy     = !clr_cnt_reg[NW];
    assign clr_cnt_next = clr_cnt_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (clr_busy) begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy) begin
            mem[clr_cnt_reg[NW-1:0]] <= '0;
        end else if (wr_en) begin
            mem[addr] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/buddy_tree_allocator.sv */
// Buddy tree allocator top level: config registers, sequencer, result register.
// Allocate: pick a level, take a free node there, block its ancestors and subtree.
// Free: align by divider, clear the block, unblock its subtree and free ancestors.
// One item at a time; all node accesses share the single memory port.
// Synchronous active-low reset; afterwards a clearing pass zeroes the node
// memory, with no item accepted meanwhile.
module buddy_tree_allocator #(
    parameter int MAX_LEVELS = 10
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bta_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_opcode,
    input  logic [bta_pkg::REQ_W-1:0]    s_req_size,
    input  logic [bta_pkg::ADDR_W-1:0]   s_free_address,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bta_pkg::STAT_W-1:0]   m_status,
    output logic [bta_pkg::ADDR_W-1:0]   m_block_address,
    output logic [bta_pkg::NODE_O_W-1:0] m_node_index,
    output logic [bta_pkg::LVL_O_W-1:0]  m_block_level
);
    import bta_pkg::*;

    localparam int NW     = MAX_LEVELS;
    localparam int LVL_W  = $clog2(MAX_LEVELS + 1);
    localparam int SH_W   = REQ_W + MAX_LEVELS + 1;
    localparam int PROD_W = NW + RB_W;

    // configuration
    logic [CFGL_W-1:0] cfg_levels_reg;
    logic [RB_W-1:0]   cfg_region_reg;
    logic [MINB_W-1:0] cfg_minb_reg;
    logic [ADDR_W-1:0] cfg_base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_levels_reg <= LEVELS_RST;
            cfg_region_reg <= REGION_RST;
            cfg_minb_reg   <= MINB_RST;
            cfg_base_reg   <= BASE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_LEVELS: cfg_levels_reg <= cfg_data[CFGL_W-1:0];
                CFG_REGION: cfg_region_reg <= cfg_data[RB_W-1:0];
                CFG_MINB:   cfg_minb_reg   <= cfg_data[MINB_W-1:0];
                CFG_BASE:   cfg_base_reg   <= cfg_data;
                default:    cfg_base_reg   <= cfg_base_reg;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    logic [LVL_W-1:0]  levels_eff;
    logic [MINB_W-1:0] minb_eff;
    logic [SH_W-1:0]   total;
    logic [SH_W-1:0]   size_eff;

    always_comb begin
        if (cfg_levels_reg == '0) begin
            levels_eff = LVL_W'(1);
        end else if (int'(cfg_levels_reg) > MAX_LEVELS) begin
            levels_eff = LVL_W'(MAX_LEVELS);
        end else begin
            levels_eff = LVL_W'(cfg_levels_reg);
        end
        minb_eff = (cfg_minb_reg == '0) ? MINB_W'(1) : cfg_minb_reg;
        total    = SH_W'(minb_eff) << levels_eff;
        size_eff = (s_req_size == '0) ? SH_W'(minb_eff) : SH_W'(s_req_size);
    end

    // node memory and divider
    logic       mem_rd, mem_wr, clr_busy;
    logic [NW-1:0] mem_addr;
    node_bits_t mem_wdata, mem_rdata;

    bta_node_store #(.NW(NW)) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (mem_rd),
        .wr_en    (mem_wr),
        .addr     (mem_addr),
        .wdata    (mem_wdata),
        .rdata    (mem_rdata),
        .clr_busy (clr_busy)
    );

    logic              div_start, div_done;
    logic [ADDR_W-1:0] div_quo;
    logic [RB_W-1:0]   div_rem;

    // sequencer state
    state_t            state_reg, state_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [LVL_W-1:0]  d_reg, d_next;
    logic [SH_W-1:0]   sh_reg, sh_next;
    logic [NW:0]       n_reg, n_next;
    logic [NW:0]       walk_reg, walk_next;
    logic [NW:0]       lo_reg, lo_next;
    logic [NW:0]       hi_reg, hi_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [ADDR_W-1:0] off_reg, off_next;
    logic [RB_W-1:0]   unit_reg, unit_next;
    logic              sub_val_reg, sub_val_next;
    logic [STAT_W-1:0] res_stat_reg, res_stat_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [NW:0]       res_node_reg, res_node_next;
    logic [LVL_W-1:0]  res_lvl_reg, res_lvl_next;
    logic              m_valid_reg, m_valid_next;
    logic [STAT_W-1:0] m_stat_reg, m_stat_next;
    logic [ADDR_W-1:0] m_addr_reg, m_addr_next;
    logic [NODE_O_W-1:0] m_node_reg, m_node_next;
    logic [LVL_O_W-1:0]  m_lvl_reg, m_lvl_next;

    logic [NW:0] first_node, end_node;

    bta_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (off_reg),
        .divisor   (unit_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign first_node = (NW+1)'(1) << lvl_reg;
    assign end_node   = (NW+1)'(2) << lvl_reg;
    assign s_ready    = (state_reg == ST_IDLE) && !clr_busy;

    always_comb begin
        state_next    = state_reg;
        lvl_next      = lvl_reg;
        d_next        = d_reg;
        sh_next       = sh_reg;
        n_next        = n_reg;
        walk_next     = walk_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        prod_next     = prod_reg;
        off_next      = off_reg;
        unit_next     = unit_reg;
        sub_val_next  = sub_val_reg;
        res_stat_next = res_stat_reg;
        res_addr_next = res_addr_reg;
        res_node_next = res_node_reg;
        res_lvl_next  = res_lvl_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_stat_next   = m_stat_reg;
        m_addr_next   = m_addr_reg;
        m_node_next   = m_node_reg;
        m_lvl_next    = m_lvl_reg;
        mem_rd        = 1'b0;
        mem_wr        = 1'b0;
        mem_addr      = walk_reg[NW-1:0];
        mem_wdata     = '0;
        div_start     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    res_stat_next = STAT_OK;
                    res_addr_next = '0;
                    res_node_next = '0;
                    res_lvl_next  = '0;
                    lvl_next      = '0;
                    if (s_opcode == OP_ALLOC) begin
                        sub_val_next = 1'b1;
                        sh_next      = size_eff;
                        if (size_eff > total) begin
                            res_stat_next = STAT_NO_BLOCK;
                            state_next    = ST_DONE;
                        end else begin
                            state_next = ST_A_LEVEL;
                        end
                    end else begin
                        sub_val_next = 1'b0;
                        off_next     = s_free_address - cfg_base_reg;
                        unit_next    = cfg_region_reg;
                        state_next   = ST_F_CHECK;
                    end
                end
            end
            ST_A_LEVEL: begin
                if ((LVL_W+1)'(lvl_reg) + 1'b1 < (LVL_W+1)'(levels_eff) &&
                    (sh_reg << 1) <= total) begin
                    sh_next  = sh_reg << 1;
                    lvl_next = lvl_reg + 1'b1;
                end else begin
                    n_next     = first_node;
                    state_next = ST_A_SCAN_RD;
                end
            end
            ST_A_SCAN_RD: begin
                if (n_reg == end_node) begin
                    res_stat_next = STAT_NO_BLOCK;
                    res_lvl_next  = '0;
                    state_next    = ST_DONE;
                end else begin
                    mem_rd     = 1'b1;
                    mem_addr   = n_reg[NW-1:0];
                    state_next = ST_A_SCAN_CHK;
                end
            end
            ST_A_SCAN_CHK: begin
                if (!mem_rdata.alloc && !mem_rdata.blocked) begin
                    state_next = ST_A_MARK;
                end else begin
                    n_next     = n_reg + 1'b1;
                    state_next = ST_A_SCAN_RD;
                end
            end
            ST_A_MARK: begin
                // node itself becomes allocated and blocked
                mem_wr     = 1'b1;
                mem_addr   = n_reg[NW-1:0];
                mem_wdata  = '{alloc: 1'b1, blocked: 1'b1};
                walk_next  = n_reg >> 1;
                state_next = ST_A_ANC_RD;
            end
            ST_A_ANC_RD: begin
                if (walk_reg == '0) begin
                    state_next = ST_A_MUL;
                end else begin
                    mem_rd     = 1'b1;
                    state_next = ST_A_ANC_CHK;
                end
            end
            ST_A_ANC_CHK: begin
                if (mem_rdata.blocked) begin
                    state_next = ST_A_MUL;
                end else begin
                    mem_wr     = 1'b1;
                    mem_wdata  = '{alloc: mem_rdata.alloc, blocked: 1'b1};
                    walk_next  = walk_reg >> 1;
                    state_next = ST_A_ANC_RD;
                end
            end
            ST_A_MUL: begin
                prod_next  = PROD_W'(n_reg - first_node) * PROD_W'(cfg_region_reg);
                state_next = ST_A_ADDR;
            end
            ST_A_ADDR: begin
                res_stat_next = STAT_OK;
                res_addr_next = cfg_base_reg + ADDR_W'(prod_reg >> lvl_reg);
                res_node_next = n_reg;
                res_lvl_next  = lvl_reg;
                state_next    = ST_SUB_INIT;
            end
            ST_F_CHECK: begin
                if (unit_reg == '0 || lvl_reg >= levels_eff) begin
                    res_stat_next = STAT_NOT_FOUND;
                    state_next    = ST_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_F_WAIT;
                end
            end
            ST_F_WAIT: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        if ((div_quo >> lvl_reg) != '0) begin
                            res_stat_next = STAT_NOT_FOUND;
                            state_next    = ST_DONE;
                        end else begin
                            n_next     = first_node | (NW+1)'(div_quo);
                            state_next = ST_F_DESC_RD;
                        end
                    end else begin
                        unit_next  = unit_reg >> 1;
                        lvl_next   = lvl_reg + 1'b1;
                        state_next = ST_F_CHECK;
                    end
                end
            end
            ST_F_DESC_RD: begin
                mem_rd     = 1'b1;
                mem_addr   = n_reg[NW-1:0];
                state_next = ST_F_DESC_CHK;
            end
            ST_F_DESC_CHK: begin
                if (mem_rdata.alloc) begin
                    state_next = ST_F_CLEAR;
                end else if ((LVL_W+1)'(lvl_reg) + 1'b1 >= (LVL_W+1)'(levels_eff)) begin
                    res_stat_next = STAT_NOT_FOUND;
                    state_next    = ST_DONE;
                end else begin
                    lvl_next   = lvl_reg + 1'b1;
                    n_next     = n_reg << 1;
                    state_next = ST_F_DESC_RD;
                end
            end
            ST_F_CLEAR: begin
                mem_wr        = 1'b1;
                mem_addr      = n_reg[NW-1:0];
                mem_wdata     = '0;
                walk_next     = n_reg;
                res_stat_next = STAT_OK;
                res_addr_next = cfg_base_reg + off_reg;
                res_node_next = n_reg;
                res_lvl_next  = lvl_reg;
                state_next    = ST_F_BUD_RD;
            end
            ST_F_BUD_RD: begin
                if (walk_reg == (NW+1)'(1)) begin
                    state_next = ST_SUB_INIT;
                end else begin
                    mem_rd     = 1'b1;
                    mem_addr   = walk_reg[NW-1:0] ^ NW'(1);
                    state_next = ST_F_BUD_CHK;
                end
            end
            ST_F_BUD_CHK: begin
                // stop unblocking once the buddy is in use
                if (mem_rdata.alloc || mem_rdata.blocked) begin
                    state_next = ST_SUB_INIT;
                end else begin
                    walk_next  = walk_reg >> 1;
                    state_next = ST_F_PAR_RD;
                end
            end
            ST_F_PAR_RD: begin
                mem_rd     = 1'b1;
                state_next = ST_F_PAR_WR;
            end
            ST_F_PAR_WR: begin
                mem_wr     = 1'b1;
                mem_wdata  = '{alloc: mem_rdata.alloc, blocked: 1'b0};
                state_next = ST_F_BUD_RD;
            end
            ST_SUB_INIT: begin
                d_next     = lvl_reg + 1'b1;
                lo_next    = n_reg << 1;
                hi_next    = (n_reg + 1'b1) << 1;
                walk_next  = n_reg << 1;
                state_next = ST_SUB_RD;
            end
            ST_SUB_RD: begin
                if (d_reg >= levels_eff) begin
                    state_next = ST_DONE;
                end else begin
                    mem_rd     = 1'b1;
                    state_next = ST_SUB_WR;
                end
            end
            ST_SUB_WR: begin
                mem_wr    = 1'b1;
                mem_wdata = '{alloc: mem_rdata.alloc, blocked: sub_val_reg};
                // advance to the next level of the subtree at the end of a row
                if (walk_reg + 1'b1 == hi_reg) begin
                    lo_next   = lo_reg << 1;
                    hi_next   = hi_reg << 1;
                    walk_next = lo_reg << 1;
                    d_next    = d_reg + 1'b1;
                end else begin
                    walk_next = walk_reg + 1'b1;
                end
                state_next = ST_SUB_RD;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_stat_next  = res_stat_reg;
                    m_addr_next  = res_addr_reg;
                    m_node_next  = NODE_O_W'(res_node_reg);
                    m_lvl_next   = LVL_O_W'(res_lvl_reg);
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lvl_reg      <= lvl_next;
        d_reg        <= d_next;
        sh_reg       <= sh_next;
        n_reg        <= n_next;
        walk_reg     <= walk_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        prod_reg     <= prod_next;
        off_reg      <= off_next;
        unit_reg     <= unit_next;
        sub_val_reg  <= sub_val_next;
        res_stat_reg <= res_stat_next;
        res_addr_reg <= res_addr_next;
        res_node_reg <= res_node_next;
        res_lvl_reg  <= res_lvl_next;
        m_stat_reg   <= m_stat_next;
        m_addr_reg   <= m_addr_next;
        m_node_reg   <= m_node_next;
        m_lvl_reg    <= m_lvl_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_stat_reg;
    assign m_block_address = m_addr_reg;
    assign m_node_index    = m_node_reg;
    assign m_block_level   = m_lvl_reg;

    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_ready)
        else $error("input accepted during memory clearing pass");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STAT_OK || m_status == STAT_NO_BLOCK ||
                     m_status == STAT_NOT_FOUND))
        else $error("undefined status code");

    a_div_only_in_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> state_reg == ST_F_CHECK)
        else $error("divider started outside the alignment search");

    a_fail_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STAT_OK) |-> (m_node_index == '0 && m_block_address == '0))
        else $error("failure result carries nonzero fields");

endmodule
